[sv/b41_pkg.sv]
// Shared types, constants and the digit-to-ASCII mapping for the base-41 text encoder.
package b41_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;
    typedef logic [10:0] quot_t;
    typedef logic [5:0]  digit_t;
    typedef logic [6:0]  char_t;
    typedef logic [1:0]  slot_t;

    localparam int unsigned DIGIT_BASE   = 41;
    localparam int unsigned UPPER_COUNT  = 26;
    localparam int unsigned FIGURE_COUNT = 10;

    // Reciprocals of 41: q = (x * RECIP) >> SHIFT is exact over each range used.
    localparam int unsigned WORD_SHIFT = 22;
    localparam logic [16:0] WORD_RECIP = 17'((1 << WORD_SHIFT) / DIGIT_BASE + 1);
    localparam int unsigned QUOT_SHIFT = 17;
    localparam logic [11:0] QUOT_RECIP = 12'((1 << QUOT_SHIFT) / DIGIT_BASE + 1);

    localparam slot_t FIRST_SLOT = 2'd0;
    localparam slot_t LAST_SLOT  = 2'd2;

    localparam char_t CHAR_UPPER_A = 7'h41;
    localparam char_t CHAR_ZERO    = 7'h30;
    localparam char_t CHAR_LOWER_A = 7'h61;

    // One word on its way into the divider stages.
    typedef struct packed {
        word_t word;
        logic  last;
    } b41_word_t;

    // Three base-41 digits of one word, least significant first.
    typedef struct packed {
        digit_t d0;
        digit_t d1;
        digit_t d2;
        logic   last;
    } b41_group_t;

    function automatic char_t digit_to_ascii(input digit_t d);
        char_t c;
        c = {1'b0, d};
        if (d < digit_t'(UPPER_COUNT))
            return CHAR_UPPER_A + c;
        else if (d < digit_t'(UPPER_COUNT + FIGURE_COUNT))
            return CHAR_ZERO + c - char_t'(UPPER_COUNT);
        else
            return CHAR_LOWER_A + c - char_t'(UPPER_COUNT + FIGURE_COUNT);
    endfunction

endpackage

[sv/b41_byte_if.sv]
// Byte channel: raw input bytes with an end-of-stream mark.
interface b41_byte_if
    import b41_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

[sv/b41_char_if.sv]
// Character channel: encoded ASCII characters with group and stream marks.
interface b41_char_if
    import b41_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t code_char;
    logic  run_end;
    logic  stream_end;

    modport source (output valid, output code_char, output run_end, output stream_end,
                    input ready);
    modport sink   (input valid, input code_char, input run_end, input stream_end,
                    output ready);
endinterface

[sv/b41_digit_pipe.sv]
// Three-stage elastic pipeline that splits a 16-bit word into three base-41 digits.
module b41_digit_pipe
    import b41_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       word_valid,
    output logic       word_ready,
    input  b41_word_t  word_in,
    output logic       grp_valid,
    input  logic       grp_ready,
    output b41_group_t grp_out
);

    // Stage 1: word register
    logic  v1_reg;
    word_t w1_reg;
    logic  last1_reg;
    // Stage 2: first quotient
    logic  v2_reg;
    word_t w2_reg;
    quot_t q1_2_reg;
    logic  last2_reg;
    // Stage 3: low digit, first quotient, top digit
    logic   v3_reg;
    digit_t d0_reg;
    quot_t  q1_3_reg;
    digit_t q2_reg;
    logic   last3_reg;

    logic load1;
    logic load2;
    logic load3;

    logic [32:0] prod1;
    quot_t       q1;
    logic [22:0] prod2;
    digit_t      q2;
    word_t       rem0;
    quot_t       rem1;

    assign load3 = !v3_reg || grp_ready;
    assign load2 = !v2_reg || load3;
    assign load1 = !v1_reg || load2;
    assign word_ready = load1;

    assign prod1 = 33'(w1_reg) * 33'(WORD_RECIP);
    assign q1    = prod1[32:22];

    assign prod2 = 23'(q1_2_reg) * 23'(QUOT_RECIP);
    assign q2    = prod2[22:17];
    assign rem0  = w2_reg - 16'(q1_2_reg) * 16'(DIGIT_BASE);

    assign rem1  = q1_3_reg - 11'(q2_reg) * 11'(DIGIT_BASE);

    assign grp_valid    = v3_reg;
    assign grp_out.d0   = d0_reg;
    assign grp_out.d1   = rem1[5:0];
    assign grp_out.d2   = q2_reg;
    assign grp_out.last = last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= word_valid;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1 && word_valid)
        begin
            w1_reg    <= word_in.word;
            last1_reg <= word_in.last;
        end
        if (load2 && v1_reg)
        begin
            w2_reg    <= w1_reg;
            q1_2_reg  <= q1;
            last2_reg <= last1_reg;
        end
        if (load3 && v2_reg)
        begin
            d0_reg    <= rem0[5:0];
            q1_3_reg  <= q1_2_reg;
            q2_reg    <= q2;
            last3_reg <= last2_reg;
        end
    end

    // Quotient from the reciprocal must leave a remainder below the base.
    a_q1_exact: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (32'(q1_2_reg) * 32'd41 <= 32'(w2_reg))
                && (32'(w2_reg) - 32'(q1_2_reg) * 32'd41 < 32'd41))
        else $error("first quotient off by one");

    a_digits_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (d0_reg < 6'd41) && (q2_reg < 6'd39)
                && (11'(q2_reg) * 11'd41 <= q1_3_reg) && (rem1 < 11'd41))
        else $error("digit out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !grp_ready |=> v3_reg && $stable(d0_reg) && $stable(q2_reg))
        else $error("stalled group lost");

endmodule

[sv/base41_text_encoder.sv]
// Top level of the base-41 text encoder: byte pairing, digit pipeline and character output.
//
// Bytes are taken one per cycle while the pipeline has room. The first byte of a pair is
// held and gives nothing; the second byte, or a final byte with nothing held, forms a
// 16-bit word (high byte zero for a lone final byte) that passes through three pipeline
// registers, where two reciprocal multiplications by 1/41 produce the digits, into a group
// register. The group register sends three characters, least significant digit first, one
// per cycle while the output channel is ready. Sustained throughput is set by the single
// character the output channel carries per cycle; short bursts up to one byte per cycle
// are absorbed by the pipeline stages.
module base41_text_encoder
    import b41_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    b41_byte_if.sink       raw,
    b41_char_if.source     text
);

    byte_t held_reg;
    byte_t held_next;
    logic  have_held_reg;
    logic  have_held_next;

    logic       grp_valid_reg;
    logic       grp_valid_next;
    slot_t      cnt_reg;
    slot_t      cnt_next;
    b41_group_t grp_reg;

    logic       raw_acc;
    logic       word_valid;
    logic       word_ready;
    b41_word_t  word_in;
    logic       dig_valid;
    b41_group_t dig_grp;
    logic       load_grp;
    digit_t     sel_digit;

    assign raw_acc    = raw.valid && raw.ready;
    assign raw.ready  = word_ready;
    assign word_valid = raw.valid && (have_held_reg || raw.final_byte);
    assign word_in.word = have_held_reg ? {raw.data_byte, held_reg} : {8'h00, raw.data_byte};
    assign word_in.last = raw.final_byte;

    b41_digit_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_in    (word_in),
        .grp_valid  (dig_valid),
        .grp_ready  (load_grp),
        .grp_out    (dig_grp)
    );

    // Pairing state: hold a first byte, drop it once its partner arrives.
    always_comb
    begin
        held_next      = held_reg;
        have_held_next = have_held_reg;
        if (raw_acc)
        begin
            if (have_held_reg)
            begin
                held_next      = 8'h00;
                have_held_next = 1'b0;
            end
            else if (!raw.final_byte)
            begin
                held_next      = raw.data_byte;
                have_held_next = 1'b1;
            end
        end
    end

    // Group register: load a new group when empty or when its last character goes out.
    always_comb
    begin
        load_grp       = !grp_valid_reg || (text.ready && cnt_reg == LAST_SLOT);
        grp_valid_next = grp_valid_reg;
        cnt_next       = cnt_reg;
        if (load_grp)
        begin
            grp_valid_next = dig_valid;
            cnt_next       = FIRST_SLOT;
        end
        else if (text.ready)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 8'h00;
            have_held_reg <= 1'b0;
            grp_valid_reg <= 1'b0;
            cnt_reg       <= FIRST_SLOT;
        end
        else
        begin
            held_reg      <= held_next;
            have_held_reg <= have_held_next;
            grp_valid_reg <= grp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_grp && dig_valid)
            grp_reg <= dig_grp;
    end

    always_comb
    begin
        case (cnt_reg)
            2'd0:    sel_digit = grp_reg.d0;
            2'd1:    sel_digit = grp_reg.d1;
            default: sel_digit = grp_reg.d2;
        endcase
    end

    assign text.valid      = grp_valid_reg;
    assign text.code_char  = digit_to_ascii(sel_digit);
    assign text.run_end    = (cnt_reg == LAST_SLOT);
    assign text.stream_end = (cnt_reg == LAST_SLOT) && grp_reg.last;

    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        raw_acc && !have_held_reg && !raw.final_byte |=> have_held_reg)
        else $error("first byte of a pair not held");

    a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
        raw_acc && have_held_reg |=> !have_held_reg)
        else $error("held byte not released after its pair");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> cnt_reg != 2'd3)
        else $error("character slot out of range");

endmodule

[tb/sv/base41_text_encoder_tb.sv]
// Self-checking testbench for base41_text_encoder: byte streams in, predicted ASCII text checked.
module base41_text_encoder_tb
    import b41_pkg::*;
;

    localparam int unsigned CLK_PERIOD   = 20;
    localparam int unsigned RUN_LIMIT    = 100000;   // cycles
    localparam int unsigned IDLE_PERCENT = 15;
    localparam int unsigned SETTLE_WAIT  = 12;       // pipeline and character slots, with margin

    typedef struct {
        char_t code_char;
        logic  run_end;
        logic  stream_end;
    } text_char_t;

    logic clk;
    logic rst_n;

    b41_byte_if byte_ch ();
    b41_char_if char_ch ();

    base41_text_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (byte_ch),
        .text  (char_ch)
    );

    // Pairing state of the predictor
    byte_t      pending_low  = '0;
    logic       low_is_held  = 1'b0;
    text_char_t pending_chars[$];

    int  fail_count    = 0;
    bit  send_idle_on  = 1'b1;
    bit  recv_idle_on  = 1'b1;
    int  recv_hold     = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT);
        $display("base41_text_encoder regression: fail");
        $finish;
    end

    function automatic char_t digit_char(input int unsigned digit);
        if (digit < UPPER_COUNT)
            return CHAR_UPPER_A + char_t'(digit);
        else if (digit < UPPER_COUNT + FIGURE_COUNT)
            return CHAR_ZERO + char_t'(digit - UPPER_COUNT);
        else
            return CHAR_LOWER_A + char_t'(digit - UPPER_COUNT - FIGURE_COUNT);
    endfunction

    // Queue the three characters of one word, least significant digit first.
    task automatic queue_word_chars(input word_t word, input logic last);
        int unsigned rest;
        text_char_t  c;
        rest = 32'(word);
        for (int k = 0; k < 3; k++)
        begin
            c.code_char  = digit_char(rest % DIGIT_BASE);
            c.run_end    = (k == 2);
            c.stream_end = (k == 2) && last;
            pending_chars.push_back(c);
            rest = rest / DIGIT_BASE;
        end
    endtask

    task automatic absorb_byte(input byte_t data, input logic last);
        if (low_is_held)
        begin
            queue_word_chars({data, pending_low}, last);
            pending_low = '0;
            low_is_held = 1'b0;
        end
        else if (last)
            queue_word_chars({8'h00, data}, 1'b1);
        else
        begin
            pending_low = data;
            low_is_held = 1'b1;
        end
    endtask

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input byte_t data, input logic last);
        while (send_idle_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= data;
        byte_ch.final_byte <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        absorb_byte(data, last);
    endtask

    // Drop valid and wait until every predicted character has come out.
    task automatic drain_text;
        byte_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    function automatic byte_t random_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Receiving side: check each character transaction, then pick the next ready.
    initial
    begin
        text_char_t want;
        char_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (char_ch.valid && char_ch.ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character: code_char %0h run_end %0b stream_end %0b",
                           char_ch.code_char, char_ch.run_end, char_ch.stream_end);
                    fail_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (char_ch.code_char !== want.code_char)
                    begin
                        $error("code_char mismatch: expected %0h, actual %0h",
                               want.code_char, char_ch.code_char);
                        fail_count++;
                    end
                    if (char_ch.run_end !== want.run_end)
                    begin
                        $error("run_end mismatch: expected %0b, actual %0b",
                               want.run_end, char_ch.run_end);
                        fail_count++;
                    end
                    if (char_ch.stream_end !== want.stream_end)
                    begin
                        $error("stream_end mismatch: expected %0b, actual %0b",
                               want.stream_end, char_ch.stream_end);
                        fail_count++;
                    end
                end
            end
            if (recv_hold > 0)
            begin
                char_ch.ready <= 1'b0;
                recv_hold--;
            end
            else if (recv_idle_on)
                char_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            else
                char_ch.ready <= 1'b1;
        end
    end

    // Extremes, digit boundaries, lone final bytes, final after final.
    task automatic test_directed;
        byte_t lone[$] = '{8'd0, 8'd25, 8'd26, 8'd35, 8'd36, 8'd40, 8'd255};
        foreach (lone[i])
            send_byte(lone[i], 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain_text();
    endtask

    // Mostly well-formed streams ending in a final byte, with some noise bursts.
    task automatic test_random_streams(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 9) < 8)
            begin
                for (int unsigned i = 0; i < len; i++)
                    send_byte(random_byte(), i == len - 1);
            end
            else
            begin
                for (int unsigned i = 0; i < len; i++)
                    send_byte(random_byte(), 1'($urandom_range(0, 1)));
            end
            sent += len;
        end
        drain_text();
    endtask

    // No idling on either side.
    task automatic test_back_to_back;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        for (int i = 0; i < 40; i++)
            send_byte(random_byte(), (i % 8) == 7);
        drain_text();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // Hold the receiver long enough for the block to fill and stall its input.
    task automatic test_output_hold;
        send_idle_on = 1'b0;
        recv_hold    = 150;
        for (int i = 0; i < 24; i++)
            send_byte(random_byte(), i == 23);
        send_idle_on = 1'b1;
        drain_text();
    endtask

    // Pause the sender between streams until all text has arrived.
    task automatic test_sender_pause;
        for (int s = 0; s < 3; s++)
        begin
            for (int i = 0; i < 4; i++)
                send_byte(random_byte(), i == 3);
            drain_text();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= '0;
        byte_ch.final_byte <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_streams(280);
        test_back_to_back();
        test_output_hold();
        test_sender_pause();

        drain_text();
        if (fail_count == 0)
            $display("base41_text_encoder regression: pass");
        else
            $display("base41_text_encoder regression: fail");
        $finish;
    end

endmodule
